/* rtl/fpms_pkg.sv */
// shared types, constants and character helpers of the fuzzy path match scorer
package fpms_pkg;

    // query geometry
    localparam int MAX_QUERY = 16;
    localparam int QIDX_W    = $clog2(MAX_QUERY);
    localparam int QPOS_W    = $clog2(MAX_QUERY + 1);

    // scoring constants
    localparam logic [6:0]  SHORT_BONUS_BASE = 7'd80;
    localparam logic [6:0]  LEN_MAX          = 7'd127;
    localparam logic [9:0]  SCORE_MAX        = 10'd1023;
    localparam logic [3:0]  BASE_BONUS       = 4'd10;
    localparam logic [2:0]  BOUNDARY_BONUS   = 3'd5;

    // separator characters
    localparam logic [7:0] CHAR_SLASH = 8'h2F;
    localparam logic [7:0] CHAR_UNDER = 8'h5F;
    localparam logic [7:0] CHAR_DASH  = 8'h2D;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_QUERY_LENGTH = 2'd0,
        CFG_CHARS_LOW    = 2'd1,
        CFG_CHARS_HIGH   = 2'd2
    } cfg_index_t;

    typedef logic [MAX_QUERY-1:0][7:0] query_t;

    // per-path scoring state
    typedef struct packed {
        logic [QPOS_W-1:0] query_pos;
        logic [4:0]        run_length;
        logic [7:0]        prev_char;
        logic              prev_was_match;
        logic              at_start;
        logic [9:0]        score_sum;
        logic [4:0]        base_match_count;
        logic [QPOS_W-1:0] base_query_pos;
        logic [6:0]        length_count;
    } path_state_t;

    // final result of one path
    typedef struct packed {
        logic       matched;
        logic [9:0] match_score;
    } path_result_t;

    localparam path_state_t PATH_STATE_RESET = '{
        query_pos:        '0,
        run_length:       '0,
        prev_char:        '0,
        prev_was_match:   1'b0,
        at_start:         1'b1,
        score_sum:        '0,
        base_match_count: '0,
        base_query_pos:   '0,
        length_count:     '0
    };

    function automatic logic is_upper(input logic [7:0] c);
        return (c >= 8'h41) && (c <= 8'h5A);
    endfunction

    function automatic logic is_lower(input logic [7:0] c);
        return (c >= 8'h61) && (c <= 8'h7A);
    endfunction

    // ascii lower-casing, bytes outside A..Z pass unchanged
    function automatic logic [7:0] fold(input logic [7:0] c);
        return is_upper(c) ? (c + 8'd32) : c;
    endfunction

endpackage

/* rtl/fpms_in_if.sv */
// path character channel
interface fpms_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] path_char;
    logic       is_final;

    modport source (output valid, output path_char, output is_final, input ready);
    modport sink   (input valid, input path_char, input is_final, output ready);
endinterface

/* rtl/fpms_out_if.sv */
// match result channel
interface fpms_out_if;
    logic       valid;
    logic       ready;
    logic       matched;
    logic [9:0] match_score;

    modport source (output valid, output matched, output match_score, input ready);
    modport sink   (input valid, input matched, input match_score, output ready);
endinterface

/* rtl/fpms_step.sv */
// per-character state update: subsequence match, bonuses and basename tracking
module fpms_step import fpms_pkg::*;
(
    input  path_state_t       state,
    input  logic [7:0]        path_char,
    input  query_t            query,
    input  logic [QPOS_W-1:0] qlen,
    output path_state_t       state_next
);

    logic [7:0]  qc;
    logic [7:0]  bqc;
    logic        active;
    logic        hit;
    logic        boundary;
    logic [4:0]  run_inc;
    logic [6:0]  ms;
    logic [10:0] score_wide;

    // query characters under both cursors
    assign qc  = query[state.query_pos[QIDX_W-1:0]];
    assign bqc = query[state.base_query_pos[QIDX_W-1:0]];

    assign active  = state.query_pos < qlen;
    assign hit     = active && (fold(qc) == fold(path_char));
    assign run_inc = state.prev_was_match ? (state.run_length + 5'd1) : 5'd0;

    // word boundary: path start, after a separator, or a lower to upper change
    assign boundary = state.at_start
                   || (state.prev_char == CHAR_SLASH) || (state.prev_char == CHAR_UNDER)
                   || (state.prev_char == CHAR_DASH)  || (state.prev_char == CHAR_DOT)
                   || (is_upper(path_char) && is_lower(state.prev_char));

    // score of this match
    assign ms = 7'd1 + {1'b0, run_inc, 1'b0}
              + (boundary ? {4'd0, BOUNDARY_BONUS} : 7'd0)
              + ((qc == path_char) ? 7'd1 : 7'd0);
    assign score_wide = {1'b0, state.score_sum} + {4'd0, ms};

    always_comb
    begin
        state_next = state;

        // main subsequence cursor
        if (hit)
        begin
            state_next.run_length       = run_inc;
            state_next.score_sum        = (score_wide > {1'b0, SCORE_MAX}) ? SCORE_MAX
                                                                         : score_wide[9:0];
            state_next.base_match_count = state.base_match_count + 5'd1;
            state_next.query_pos        = state.query_pos + QPOS_W'(1);
            state_next.prev_was_match   = 1'b1;
        end
        else
        begin
            if (active)
            begin
                state_next.run_length = '0;
            end
            state_next.prev_was_match = 1'b0;
        end

        // basename cursor restarts at each slash
        if (path_char == CHAR_SLASH)
        begin
            state_next.base_match_count = '0;
            state_next.base_query_pos   = '0;
        end
        else if ((state.base_query_pos < qlen) && (fold(path_char) == fold(bqc)))
        begin
            state_next.base_query_pos = state.base_query_pos + QPOS_W'(1);
        end

        // path length, saturating
        if (state.length_count < LEN_MAX)
        begin
            state_next.length_count = state.length_count + 7'd1;
        end
        state_next.prev_char = path_char;
        state_next.at_start  = 1'b0;
    end

endmodule

/* rtl/fpms_result.sv */
// end-of-path score: basename, length and full-basename bonuses
module fpms_result import fpms_pkg::*;
(
    input  path_state_t       state,
    input  logic [QPOS_W-1:0] qlen,
    output path_result_t      result
);

    logic [6:0]  len_bonus;
    logic [10:0] total;

    assign len_bonus = (state.length_count < SHORT_BONUS_BASE)
                     ? (SHORT_BONUS_BASE - state.length_count) : 7'd0;

    // all terms are non-negative, so one saturation at the end suffices
    assign total = {1'b0, state.score_sum}
                 + {5'd0, state.base_match_count, 1'b0}
                 + {4'd0, len_bonus}
                 + ((state.base_query_pos >= qlen) ? {7'd0, BASE_BONUS} : 11'd0);

    always_comb
    begin
        if (qlen == '0)
        begin
            result.matched     = 1'b1;
            result.match_score = 10'd1;
        end
        else if (state.query_pos >= qlen)
        begin
            result.matched     = 1'b1;
            result.match_score = (total > {1'b0, SCORE_MAX}) ? SCORE_MAX : total[9:0];
        end
        else
        begin
            result.matched     = 1'b0;
            result.match_score = '0;
        end
    end

endmodule

/* rtl/fuzzy_path_match_scorer_unit.sv */
// Fuzzy path match scorer: streams path bytes and scores them against a query.
//
// Channels: "path" carries one byte of a candidate path per transfer, with
// is_final set on the last byte. "result" carries one transfer per path
// (matched flag and saturated score), produced by the byte marked final.
// The query is loaded through the cfg write port (length, low and high
// character words) while no path is in flight, a rule for the user that the
// block does not enforce. Throughput: one path byte per cycle unless a final
// byte waits behind a held result, set by the feedback of the scoring state
// through the per-character update logic. A byte is registered in the input
// register at its transfer, and the result of a final byte is registered in
// the output register. A stalled result holds in the output register; the
// input register still takes bytes until a final byte is waiting behind the
// held result, and then path.ready drops until the result transfers.
// Reset clears the query registers to an empty query, all path state and
// both valid flags; no clearing pass is needed.
module fuzzy_path_match_scorer_unit import fpms_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    fpms_in_if.sink     path,
    fpms_out_if.source  result,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    logic [4:0]        query_length_reg;
    query_t            query_reg;
    logic [QPOS_W-1:0] qlen;

    logic              stage_valid_reg;
    logic [7:0]        stage_char_reg;
    logic              stage_final_reg;
    logic              stage_adv;

    path_state_t       state_reg;
    path_state_t       state_step;
    path_state_t       state_next;
    path_result_t      res_comb;

    logic              out_valid_reg;
    path_result_t      out_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_length_reg <= '0;
            query_reg        <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUERY_LENGTH: query_length_reg <= cfg_data[4:0];
                CFG_CHARS_LOW:    query_reg[7:0]   <= cfg_data;
                CFG_CHARS_HIGH:   query_reg[15:8]  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // lengths above the maximum act as the maximum
    assign qlen = (query_length_reg > 5'(MAX_QUERY)) ? QPOS_W'(MAX_QUERY)
                                                     : QPOS_W'(query_length_reg);

    // the scored byte moves on unless a final result would hit a held output
    assign stage_adv  = stage_valid_reg
                     && (!stage_final_reg || !out_valid_reg || result.ready);
    assign path.ready = !stage_valid_reg || stage_adv;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (path.ready)
        begin
            stage_valid_reg <= path.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (path.valid && path.ready)
        begin
            stage_char_reg  <= path.path_char;
            stage_final_reg <= path.is_final;
        end
    end

    fpms_step u_step (
        .state      (state_reg),
        .path_char  (stage_char_reg),
        .query      (query_reg),
        .qlen       (qlen),
        .state_next (state_step)
    );

    fpms_result u_result (
        .state  (state_step),
        .qlen   (qlen),
        .result (res_comb)
    );

    // path state returns to reset after the final byte
    assign state_next = stage_final_reg ? PATH_STATE_RESET : state_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PATH_STATE_RESET;
        end
        else if (stage_adv)
        begin
            state_reg <= state_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (stage_adv && stage_final_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_adv && stage_final_reg)
        begin
            out_reg <= res_comb;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.matched     = out_reg.matched;
    assign result.match_score = out_reg.match_score;

`ifndef ASSERT_OFF
    // a final byte leaves the path state at its reset value
    a_state_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_adv && stage_final_reg) |=> (state_reg == PATH_STATE_RESET))
        else $error("path state not cleared after final byte");

    // a new result appears only after a final byte was scored
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_adv && stage_final_reg))
        else $error("result valid without a scored final byte");

    // a miss always carries a zero score
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && !result.matched) |-> (result.match_score == '0))
        else $error("unmatched result with nonzero score");

    // the query cursor never passes the query
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid_reg |-> (state_reg.query_pos <= QPOS_W'(MAX_QUERY)))
        else $error("query cursor out of range");
`endif

endmodule
